// File: rtl/core/cacu_pkg.sv
// Package for the continuous cellular automaton cell update engine.
// Holds sizes, fixed-point rule constants, FSM state type and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package cacu_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = 1 + YW + XW;
	localparam int DEPTH  = 2 * MAX_WIDTH * MAX_HEIGHT;

	localparam int VAL_W  = 15;
	localparam int SIZE_W = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CW     = 14;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// Q14 constants, 1.0 = 16384
	localparam logic [VAL_W-1:0] ONE_Q   = 15'd16384;
	localparam logic [CW-1:0]    C_PUSH  = 14'd2949;
	localparam logic [CW-1:0]    C_TENTH = 14'd1638;
	localparam logic [CW-1:0]    C_SEP   = 14'd164;
	localparam logic [CW-1:0]    C_LOW   = 14'd819;
	localparam logic [CW-1:0]    C_HIGH  = 14'd15565;
	localparam logic [CW-1:0]    C_NINE  = 14'd14746;

	localparam int NB_COUNT = 5;
	localparam int NB_CNT_W = $clog2(NB_COUNT + 1);

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		NB_CENTER = 3'd0,
		NB_LEFT   = 3'd1,
		NB_RIGHT  = 3'd2,
		NB_TOP    = 3'd3,
		NB_BOTTOM = 3'd4
	} nb_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC1,
		ST_CALC2,
		ST_CALC3,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    rd_en;
		nb_sel_t rd_sel;
		logic    shift_en;
		logic    calc1;
		logic    calc2;
		logic    calc3;
		logic    finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/core/cacu_ctrl.sv
// Controller FSM of the cell update engine: sequences neighbor fetch,
// rule stages and result hand-off. Depends on cacu_pkg.
`timescale 1ns / 1ps

module cacu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                operation,
	input  cacu_pkg::dp_status_t status,
	output cacu_pkg::ctrl_cmd_t  cmd,
	output logic                in_stall
);
	import cacu_pkg::*;

	state_t              state_q;
	state_t              state_nxt;
	logic [NB_CNT_W-1:0] fetch_cnt_q;
	logic                fetch_done;

	assign fetch_done = (fetch_cnt_q == NB_CNT_W'(NB_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fetch_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_FETCH && !fetch_done) begin
				fetch_cnt_q <= fetch_cnt_q + 1'b1;
			end else begin
				fetch_cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (op_t'(operation) == OP_STEP) ? ST_FETCH : ST_FINISH;
				end
			end
			ST_FETCH: begin
				if (fetch_done) begin
					state_nxt = ST_CALC1;
				end
			end
			ST_CALC1:  state_nxt = ST_CALC2;
			ST_CALC2:  state_nxt = ST_CALC3;
			ST_CALC3:  state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = NB_CENTER;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_FETCH: begin
				// reads go out on counts 0..4, data shifts in on the following count
				cmd.rd_en    = !fetch_done;
				cmd.rd_sel   = nb_sel_t'(fetch_cnt_q);
				cmd.shift_en = (fetch_cnt_q != '0);
			end
			ST_CALC1:  cmd.calc1 = 1'b1;
			ST_CALC2:  cmd.calc2 = 1'b1;
			ST_CALC3:  cmd.calc3 = 1'b1;
			ST_FINISH: cmd.finish = status.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// File: rtl/core/cacu_dp.sv
// Datapath of the cell update engine: frame store, cursor, size registers,
// neighbor shift line, rule arithmetic and output register. Depends on cacu_pkg.
`timescale 1ns / 1ps

module cacu_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cacu_pkg::ctrl_cmd_t                    cmd,
	output cacu_pkg::dp_status_t                   status,
	input  logic                                  operation,
	input  logic [cacu_pkg::VAL_W-1:0]            load_value,
	input  logic                                  write_enable,
	input  logic [cacu_pkg::CFG_INDEX_W-1:0]      register_index,
	input  logic [cacu_pkg::SIZE_W-1:0]           write_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cacu_pkg::VAL_W-1:0]            cell_value,
	output logic [cacu_pkg::XW-1:0]               cell_x,
	output logic [cacu_pkg::YW-1:0]               cell_y,
	output logic                                  last_of_frame
);
	import cacu_pkg::*;

	logic [VAL_W-1:0] frame_mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] mem_addr;

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;
	logic [XW-1:0]     cursor_x_q;
	logic [YW-1:0]     cursor_y_q;
	logic              front_q;

	logic              op_q;
	logic [VAL_W-1:0]  load_q;
	logic [VAL_W-1:0]  nb_q [NB_COUNT];

	logic [XW:0] w_eff;
	logic [YW:0] h_eff;
	logic [XW-1:0] xn, xl, xr, x_rd;
	logic [YW-1:0] yn, yt, yb, y_rd;
	logic x_end, y_end, last;

	logic [VAL_W-1:0] k_q, j_q, pk_q, tk_q;
	logic [VAL_W:0]   e1_q, p9_q;
	logic signed [17:0] e2_q;

	logic [VAL_W-1:0] e_c, l_c, r_c, t_c, b_c;
	logic [VAL_W:0]   hsum, vsum;
	logic [VAL_W-1:0] h_c, v_c, k_c, j_c;
	logic [VAL_W+CW-1:0] prod_push, prod_tenth;
	logic [VAL_W:0]   e1_c;
	logic [VAL_W+CW:0] prod_nine;
	logic signed [17:0] ks, e2_c, e3_c;
	logic [VAL_W-1:0] new_value, result_value;

	logic out_valid_q;
	logic [VAL_W-1:0] cell_value_q;
	logic [XW-1:0]    cell_x_q;
	logic [YW-1:0]    cell_y_q;
	logic             last_q;

	// Effective sizes: zero acts as one, oversize clips to the maximum
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = (XW+1)'(1);
		end else if ({1'b0, frame_width_q} > (SIZE_W+1)'(MAX_WIDTH)) begin
			w_eff = (XW+1)'(MAX_WIDTH);
		end else begin
			w_eff = (XW+1)'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = (YW+1)'(1);
		end else if ({1'b0, frame_height_q} > (SIZE_W+1)'(MAX_HEIGHT)) begin
			h_eff = (YW+1)'(MAX_HEIGHT);
		end else begin
			h_eff = (YW+1)'(frame_height_q);
		end
	end

	// Cursor with out-of-range coordinates folded to zero, plus wrapped neighbors
	always_comb begin
		xn    = ({1'b0, cursor_x_q} >= w_eff) ? '0 : cursor_x_q;
		yn    = ({1'b0, cursor_y_q} >= h_eff) ? '0 : cursor_y_q;
		x_end = ({1'b0, xn} + 1'b1 == w_eff);
		y_end = ({1'b0, yn} + 1'b1 == h_eff);
		last  = x_end && y_end;
		xl    = (xn == '0) ? XW'(w_eff - 1'b1) : xn - 1'b1;
		xr    = x_end ? '0 : xn + 1'b1;
		yt    = (yn == '0) ? YW'(h_eff - 1'b1) : yn - 1'b1;
		yb    = y_end ? '0 : yn + 1'b1;
	end

	always_comb begin
		x_rd = xn;
		y_rd = yn;
		case (cmd.rd_sel)
			NB_CENTER: begin
				x_rd = xn;
				y_rd = yn;
			end
			NB_LEFT:   x_rd = xl;
			NB_RIGHT:  x_rd = xr;
			NB_TOP:    y_rd = yt;
			NB_BOTTOM: y_rd = yb;
			default: begin
				x_rd = xn;
				y_rd = yn;
			end
		endcase
	end

	always_comb begin
		if (cmd.finish) begin
			mem_addr = {front_q ^ op_q, yn, xn};
		end else begin
			mem_addr = {front_q, y_rd, x_rd};
		end
	end

	// Frame store, single port
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			frame_mem[mem_addr] <= result_value;
		end else if (cmd.rd_en) begin
			rd_data_q <= frame_mem[mem_addr];
		end
	end

	// Rule, first stage: neighbor means, k, distance and the two k products
	always_comb begin
		e_c = nb_q[NB_CENTER];
		l_c = nb_q[NB_LEFT];
		r_c = nb_q[NB_RIGHT];
		t_c = nb_q[NB_TOP];
		b_c = nb_q[NB_BOTTOM];
		hsum = {1'b0, l_c} + {1'b0, r_c};
		vsum = {1'b0, t_c} + {1'b0, b_c};
		h_c  = hsum[VAL_W:1];
		v_c  = vsum[VAL_W:1];
		k_c  = (h_c > v_c) ? h_c : v_c;
		j_c  = (e_c > k_c) ? e_c - k_c : k_c - e_c;
		prod_push  = k_c * C_PUSH;
		prod_tenth = k_c * C_TENTH;
	end

	// Second stage: push or pull toward k, then the 0.9 product
	always_comb begin
		if (e_c < k_q) begin
			e1_c = {1'b0, e_c} + {1'b0, pk_q};
		end else if (e_c > k_q) begin
			e1_c = {1'b0, e_c} - {1'b0, tk_q};
		end else begin
			e1_c = {1'b0, e_c};
		end
		prod_nine = e1_c * C_NINE;
	end

	// Third stage: keep the separation or blend toward k
	always_comb begin
		ks = $signed({3'b000, k_q});
		if (j_q < VAL_W'(C_SEP)) begin
			if (e1_q > {1'b0, k_q}) begin
				e2_c = ks - $signed(18'(C_SEP));
			end else if (e1_q < {1'b0, k_q}) begin
				e2_c = ks + $signed(18'(C_SEP));
			end else begin
				e2_c = ks;
			end
		end else begin
			e2_c = $signed({2'b00, p9_q}) + $signed({3'b000, tk_q});
		end
	end

	// Last stage: dark-cell expansion, bright-cell slowdown, then clamp; a load passes load_q instead
	always_comb begin
		if (e2_q <= $signed(18'(C_LOW)) && k_q > VAL_W'(C_LOW)) begin
			e3_c = ks + $signed(18'(C_TENTH));
		end else if (e2_q >= $signed(18'(C_HIGH)) && k_q < VAL_W'(C_HIGH)) begin
			e3_c = ks - $signed(18'(C_TENTH));
		end else if (e2_q > ks) begin
			e3_c = e2_q - $signed({4'b0000, j_q[VAL_W-1:1]});
		end else begin
			e3_c = e2_q;
		end
		if (e3_c > $signed({3'b000, ONE_Q})) begin
			new_value = ONE_Q;
		end else if (e3_c < 0) begin
			new_value = '0;
		end else begin
			new_value = e3_c[VAL_W-1:0];
		end
		result_value = (op_t'(op_q) == OP_STEP) ? new_value : load_q;
	end

	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			load_q <= (load_value > ONE_Q) ? ONE_Q : load_value;
		end
		if (cmd.shift_en) begin
			for (int i = 0; i < NB_COUNT - 1; i++) begin
				nb_q[i] <= nb_q[i+1];
			end
			nb_q[NB_COUNT-1] <= rd_data_q;
		end
		if (cmd.calc1) begin
			k_q  <= k_c;
			j_q  <= j_c;
			pk_q <= prod_push[VAL_W+CW-1:CW];
			tk_q <= prod_tenth[VAL_W+CW-1:CW];
		end
		if (cmd.calc2) begin
			e1_q <= e1_c;
			p9_q <= prod_nine[VAL_W+CW:CW];
		end
		if (cmd.calc3) begin
			e2_q <= e2_c;
		end
		if (cmd.finish) begin
			cell_value_q <= result_value;
			cell_x_q     <= xn;
			cell_y_q     <= yn;
			last_q       <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_W'(MAX_WIDTH);
			frame_height_q <= SIZE_W'(MAX_HEIGHT);
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			front_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (write_enable) begin
				case (register_index)
					REG_FRAME_WIDTH:  frame_width_q  <= write_data;
					REG_FRAME_HEIGHT: frame_height_q <= write_data;
					default: ;
				endcase
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				// advance in raster order
				if (x_end) begin
					cursor_x_q <= '0;
					cursor_y_q <= y_end ? '0 : yn + 1'b1;
				end else begin
					cursor_x_q <= xn + 1'b1;
					cursor_y_q <= yn;
				end
				if (op_t'(op_q) == OP_STEP && last) begin
					front_q <= !front_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_value    = cell_value_q;
	assign cell_x        = cell_x_q;
	assign cell_y        = cell_y_q;
	assign last_of_frame = last_q;

endmodule

// File: rtl/core/continuous_automaton_cell_update.sv
// Load: accepted in idle, written to the front frame and the output register in
// finish. Step: accepted in idle, five neighbor reads on the single-ported frame
// store in fetch, three rule stages, then the write to the back frame in finish.
// Finish waits on a stalled output; no new item is taken until back in idle.
// Reset clears cursor, frame select, size registers (128 x 128) and handshake
// state; frame store contents stay undefined until loaded.
`timescale 1ns / 1ps

module continuous_automaton_cell_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [cacu_pkg::VAL_W-1:0]       load_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [cacu_pkg::VAL_W-1:0]       cell_value,
	output logic [cacu_pkg::XW-1:0]          cell_x,
	output logic [cacu_pkg::YW-1:0]          cell_y,
	output logic                             last_of_frame,
	input  logic                             write_enable,
	input  logic [cacu_pkg::CFG_INDEX_W-1:0] register_index,
	input  logic [cacu_pkg::SIZE_W-1:0]      write_data
);
	import cacu_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	cacu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	cacu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (operation),
		.load_value     (load_value),
		.write_enable   (write_enable),
		.register_index (register_index),
		.write_data     (write_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cell_value     (cell_value),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.last_of_frame  (last_of_frame)
	);

endmodule

// File: test/testbench.sv
// Self-checking bench for continuous_automaton_cell_update: loads and steps small
// toroidal grids, predicts every cell result and compares it on the output port.
// Depends on cacu_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
	import cacu_pkg::*;

	localparam int ITEMS = 1350;
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [XW-1:0]    x;
		logic [YW-1:0]    y;
		logic             last;
	} cell_rec_t;

	class cell_update_tracker;
		localparam int ONE   = ONE_Q;
		localparam int PUSH  = C_PUSH;
		localparam int TENTH = C_TENTH;
		localparam int SEP   = C_SEP;
		localparam int LOW   = C_LOW;
		localparam int HIGH  = C_HIGH;
		localparam int NINE  = C_NINE;

		logic [VAL_W-1:0] frame_mem [2][CELLS];
		bit               filled [2][CELLS];
		int unsigned      nbr [5];
		int unsigned      cur_x, cur_y;
		int unsigned      width_reg = MAX_WIDTH;
		int unsigned      height_reg = MAX_HEIGHT;
		bit               front;
		cell_rec_t        pending [$];
		int               fails, loads, steps, swaps;

		function int unsigned span(int unsigned raw, int unsigned limit);
			if (raw == 0)
				return 1;
			return (raw > limit) ? limit : raw;
		endfunction

		function void configure(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data;
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = data;
		endfunction

		// Cursor as the block sees it: an out-of-range coordinate falls back to 0
		function void place(output int unsigned x, output int unsigned y,
		                    output int unsigned w, output int unsigned h);
			w = span(width_reg, MAX_WIDTH);
			h = span(height_reg, MAX_HEIGHT);
			x = (cur_x >= w) ? 0 : cur_x;
			y = (cur_y >= h) ? 0 : cur_y;
		endfunction

		// Order: centre, left, right, top, bottom, all wrapped
		function void gather(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
			int unsigned xl, xr, yt, yb;
			xl = (x == 0) ? w - 1 : x - 1;
			xr = (x + 1 == w) ? 0 : x + 1;
			yt = (y == 0) ? h - 1 : y - 1;
			yb = (y + 1 == h) ? 0 : y + 1;
			nbr[0] = y * MAX_WIDTH + x;
			nbr[1] = y * MAX_WIDTH + xl;
			nbr[2] = y * MAX_WIDTH + xr;
			nbr[3] = yt * MAX_WIDTH + x;
			nbr[4] = yb * MAX_WIDTH + x;
		endfunction

		function bit step_ready();
			int unsigned x, y, w, h;
			place(x, y, w, h);
			gather(x, y, w, h);
			foreach (nbr[i])
				if (!filled[front][nbr[i]])
					return 0;
			return 1;
		endfunction

		function int scale(int c, int v);
			return (c * v) / 16384;
		endfunction

		function int next_cell_value(int e, int l, int r, int t, int b);
			int h, v, k, j;
			h = (l + r) / 2;
			v = (t + b) / 2;
			k = (h > v) ? h : v;
			j = (e > k) ? e - k : k - e;
			if (e < k)
				e += scale(PUSH, k);
			else if (e > k)
				e -= scale(TENTH, k);
			// keep a small separation from k when already close
			if (j < SEP) begin
				if (e > k)
					e = k - SEP;
				else if (e < k)
					e = k + SEP;
				else
					e = k;
			end else begin
				e = scale(NINE, e) + scale(TENTH, k);
			end
			if (e <= LOW && k > LOW)
				e = k + TENTH;
			else if (e >= HIGH && k < HIGH)
				e = k - TENTH;
			else if (e > k)
				e -= j / 2;
			if (e > ONE)
				e = ONE;
			if (e < 0)
				e = 0;
			return e;
		endfunction

		function void accept_item(op_t kind, logic [VAL_W-1:0] lv);
			int unsigned x, y, w, h;
			int          val;
			bit          last;
			cell_rec_t   rec;
			place(x, y, w, h);
			last = (x + 1 == w) && (y + 1 == h);
			if (kind == OP_LOAD) begin
				val = (lv > ONE_Q) ? ONE : int'(lv);
				frame_mem[front][y * MAX_WIDTH + x] = val[VAL_W-1:0];
				filled[front][y * MAX_WIDTH + x] = 1'b1;
				loads++;
			end else begin
				gather(x, y, w, h);
				val = next_cell_value(frame_mem[front][nbr[0]], frame_mem[front][nbr[1]],
				                      frame_mem[front][nbr[2]], frame_mem[front][nbr[3]],
				                      frame_mem[front][nbr[4]]);
				frame_mem[!front][nbr[0]] = val[VAL_W-1:0];
				filled[!front][nbr[0]] = 1'b1;
				steps++;
				// only a step at the last cell swaps the frames
				if (last) begin
					front = !front;
					swaps++;
				end
			end
			if (x + 1 < w) begin
				cur_x = x + 1;
				cur_y = y;
			end else begin
				cur_x = 0;
				cur_y = (y + 1 < h) ? y + 1 : 0;
			end
			rec.value = val[VAL_W-1:0];
			rec.x = x[XW-1:0];
			rec.y = y[YW-1:0];
			rec.last = last;
			pending.push_back(rec);
		endfunction

		function void fault(string msg);
			if (fails < 10)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			fails++;
		endfunction

		function void check_cell(logic [VAL_W-1:0] v, logic [XW-1:0] x, logic [YW-1:0] y,
		                         logic last);
			cell_rec_t want;
			if (pending.size() == 0) begin
				fault($sformatf("unexpected cell value=%0d x=%0d y=%0d last=%0b",
				                v, x, y, last));
				return;
			end
			want = pending.pop_front();
			if (v !== want.value || x !== want.x || y !== want.y || last !== want.last)
				fault($sformatf("expected value=%0d x=%0d y=%0d last=%0b, got value=%0d x=%0d y=%0d last=%0b",
				                want.value, want.x, want.y, want.last, v, x, y, last));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   operation = 1'b0;
	logic [VAL_W-1:0]       load_value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b1;
	logic [VAL_W-1:0]       cell_value;
	logic [XW-1:0]          cell_x;
	logic [YW-1:0]          cell_y;
	logic                   last_of_frame;
	logic                   write_enable = 1'b0;
	logic [CFG_INDEX_W-1:0] register_index = '0;
	logic [SIZE_W-1:0]      write_data = '0;

	cell_update_tracker cells = new();
	int send_idle_pct = 9;
	int recv_idle_pct = 83;
	int n_sent;
	int n_shapes;

	continuous_automaton_cell_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.load_value(load_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_value(cell_value),
		.cell_x(cell_x),
		.cell_y(cell_y),
		.last_of_frame(last_of_frame),
		.write_enable(write_enable),
		.register_index(register_index),
		.write_data(write_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0)
			cells.check_cell(cell_value, cell_x, cell_y, last_of_frame);
	end

	// Send one transaction; a step whose neighborhood is not loaded yet goes out as a load
	task automatic push(input op_t op, input logic [VAL_W-1:0] lv);
		op_t kind;
		kind = op;
		if (kind == OP_STEP && !cells.step_ready())
			kind = OP_LOAD;
		case (n_sent * 3 / ITEMS)
			0: begin
				send_idle_pct = 9;
				recv_idle_pct = 83;
			end
			1: begin
				send_idle_pct = 83;
				recv_idle_pct = 9;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= kind;
		load_value <= lv;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		cells.accept_item(kind, lv);
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cells.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_size(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw);
		drain();
		write_enable <= 1'b1;
		register_index <= REG_FRAME_WIDTH;
		write_data <= w_raw;
		@(posedge clk);
		cells.configure(REG_FRAME_WIDTH, w_raw);
		register_index <= REG_FRAME_HEIGHT;
		write_data <= h_raw;
		@(posedge clk);
		cells.configure(REG_FRAME_HEIGHT, h_raw);
		write_enable <= 1'b0;
		n_shapes++;
	endtask

	// Mode 0 spreads values over 0..1, mode 1 clusters them around base; both also pick edge and out-of-range values
	function automatic logic [VAL_W-1:0] pick_level(int mode, int base);
		int r, v, d;
		r = $urandom_range(99);
		if (r < 6)
			return VAL_W'($urandom_range(32767));
		if (r < 14) begin
			case ($urandom_range(5))
				0: return '0;
				1: return VAL_W'(C_LOW);
				2: return VAL_W'(C_HIGH);
				3: return ONE_Q;
				4: return 15'h7FFF;
				default: return VAL_W'($urandom_range(32767, 16385));
			endcase
		end
		if (mode == 0)
			return VAL_W'($urandom_range(16384));
		d = $urandom_range(400);
		v = base + d - 200;
		if (v < 0)
			v = 0;
		if (v > 16384)
			v = 16384;
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [SIZE_W-1:0] raw_size(int unsigned eff, int unsigned limit);
		if (eff == 1 && $urandom_range(1) == 1)
			return '0;
		if (eff == limit && $urandom_range(1) == 1)
			return SIZE_W'($urandom_range(255, limit + 1));
		return eff[SIZE_W-1:0];
	endfunction

	// Fill the whole grid, then run a few step passes with occasional stray loads
	task automatic run_shape(input logic [SIZE_W-1:0] w_raw, input logic [SIZE_W-1:0] h_raw);
		int unsigned n, passes, len;
		int mode, base;
		set_size(w_raw, h_raw);
		n = cells.span(w_raw, MAX_WIDTH) * cells.span(h_raw, MAX_HEIGHT);
		mode = $urandom_range(1);
		base = $urandom_range(16384);
		// stop once the item budget is spent
		for (int i = 0; i < n && n_sent < ITEMS; i++)
			push(OP_LOAD, pick_level(mode, base));
		passes = (n > 32) ? $urandom_range(2, 1) : $urandom_range(4, 1);
		for (int p = 0; p < passes; p++) begin
			len = ($urandom_range(99) < 5) ? $urandom_range(n) : n;
			for (int i = 0; i < len && n_sent < ITEMS; i++) begin
				if ($urandom_range(99) < 4)
					push(OP_LOAD, pick_level(mode, base));
				else
					push(OP_STEP, VAL_W'($urandom_range(32767)));
			end
		end
	endtask

	initial begin
		int r;
		int unsigned w, h;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: extremes and saturation of the load value
		push(OP_LOAD, '0);
		push(OP_LOAD, ONE_Q);
		push(OP_LOAD, 15'd16385);
		push(OP_LOAD, 15'h7FFF);
		push(OP_LOAD, 15'h2AAA);
		push(OP_LOAD, 15'h5555);
		// zero width acts as one, cursor beyond the new size restarts at 0
		set_size(8'd0, 8'd1);
		push(OP_LOAD, 15'd8000);
		push(OP_STEP, 15'h7FFF);
		push(OP_STEP, '0);
		// load at the last cell must not swap, then steps far from and near k
		set_size(8'd3, 8'd1);
		push(OP_LOAD, ONE_Q);
		push(OP_LOAD, '0);
		push(OP_LOAD, ONE_Q);
		repeat (3) push(OP_STEP, 15'h2AAA);
		push(OP_LOAD, 15'd8000);
		push(OP_LOAD, 15'd8100);
		push(OP_LOAD, 15'd8050);
		repeat (3) push(OP_STEP, 15'h5555);

		run_shape(8'd255, 8'd1);
		run_shape(8'd0, 8'd128);
		while (n_sent < ITEMS) begin
			r = $urandom_range(99);
			if (r < 80) begin
				w = $urandom_range(9, 1);
				h = $urandom_range(9, 1);
			end else if (r < 90) begin
				w = $urandom_range(MAX_WIDTH, 96);
				h = $urandom_range(2, 1);
			end else begin
				w = $urandom_range(2, 1);
				h = $urandom_range(MAX_HEIGHT, 96);
			end
			run_shape(raw_size(w, MAX_WIDTH), raw_size(h, MAX_HEIGHT));
		end

		drain();
		repeat (24) @(posedge clk);
		$display("Covered %0d loads and %0d steps over %0d grid sizes with %0d frame swaps",
		         cells.loads, cells.steps, n_shapes, cells.swaps);
		$display("Mismatches: %0d", cells.fails);
		if (cells.fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
